### design/tgf_pkg.sv
package tgf_pkg;

  localparam int IdxW     = 12;
  localparam int CoordW   = 32;
  localparam int DeltaW   = 31;
  localparam int ProdW    = 2 * DeltaW;
  localparam int VecW     = 64;
  localparam int MagW     = VecW - 1;
  localparam int NormW    = 30;
  localparam int SqW      = 62;
  localparam int LenW     = 31;
  localparam int QW       = 15;
  localparam int RemW     = LenW + QW - 1;
  localparam int OutW     = 16;
  localparam int PosW     = 3 * CoordW;
  localparam int UvW      = 2 * CoordW;
  localparam int InDataW  = 184;
  localparam int OutDataW = 6 * OutW;

  localparam int PositionDepthDef = 4096;
  localparam int UvDepthDef       = 4096;

  localparam logic [SqW-1:0] SqrtTopBit = SqW'(1) << (SqW - 2);

  typedef enum logic [1:0] {
    CMD_LOAD_POS = 2'd0,
    CMD_LOAD_UV  = 2'd1,
    CMD_FACE     = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_RD_C,
    ST_RD_END,
    ST_MUL,
    ST_ABS,
    ST_SHIFT,
    ST_SQ,
    ST_SQRT,
    ST_DIV_INIT,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

### design/triangle_tangent_frame.sv
// Channel   Dir  tdata                                            tuser
// s_axis    in   store_index, coord_x/y/z, pos_index_a..c,        command
//                uv_index_a..c (184 bits)
// m_axis    out  tangent_x/y/z, bitangent_x/y/z (96 bits)         degenerate
// Load requests are written as they are accepted. A face request holds s_axis_tready low
// until it is done; each vector is normalized by one-bit-per-cycle shifts, and the
// shared 31x31 multiplier, the bit-serial square root and the 15-step divider do the work.
// Reset clears control only; the stores are not cleared and read undefined until written.
// The result sits in an output register; a stalled m_axis holds the next face at its end.
module triangle_tangent_frame
  import tgf_pkg::*;
#(
  parameter int POSITION_DEPTH = PositionDepthDef,
  parameter int UV_DEPTH       = UvDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // store_index, coord_x, coord_y, coord_z, pos_index_a, pos_index_b,
  // pos_index_c, uv_index_a, uv_index_b, uv_index_c, zero fill
  input  logic [InDataW-1:0]  s_axis_tdata,
  // command
  input  logic [1:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y, bitangent_z
  output logic [OutDataW-1:0] m_axis_tdata,
  // degenerate
  output logic [0:0]          m_axis_tuser
);

  function automatic logic signed [DeltaW-1:0] sat_delta(
    input logic signed [CoordW-1:0] a,
    input logic signed [CoordW-1:0] b
  );
    logic signed [CoordW:0] d;
    d = {a[CoordW-1], a} - {b[CoordW-1], b};
    if (!d[CoordW] && (d[CoordW-1:DeltaW-1] != '0)) begin
      return {1'b0, {(DeltaW-1){1'b1}}};
    end else if (d[CoordW] && (d[CoordW-1:DeltaW-1] != '1)) begin
      return {1'b1, {(DeltaW-1){1'b0}}};
    end
    return d[DeltaW-1:0];
  endfunction

  state_e state_q, state_d;

  cmd_e            cmd;
  logic            accept;
  logic            face_start;
  logic [IdxW-1:0] pos_raddr, uv_raddr;
  logic [PosW-1:0] pos_rdata;
  logic [UvW-1:0]  uv_rdata;

  logic [IdxW-1:0] pidx_q [3];
  logic [IdxW-1:0] uidx_q [3];

  logic signed [CoordW-1:0] pr [3];
  logic signed [CoordW-1:0] ur [2];
  logic signed [CoordW-1:0] p0_q [3];
  logic signed [CoordW-1:0] t0_q [2];
  logic signed [DeltaW-1:0] e1_q [3];
  logic signed [DeltaW-1:0] e2_q [3];
  logic signed [DeltaW-1:0] du1_q, dv1_q, du2_q, dv2_q;

  logic [3:0] k_q;
  logic       ph_q;
  logic       vi_q;
  logic [3:0] cnt_q;

  logic signed [DeltaW-1:0] mul_a, mul_b;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [VecW-1:0]   acc_q;
  logic signed [VecW-1:0]   diff;
  logic                     det_neg_q;
  logic                     degen_q;
  logic signed [VecW-1:0]   vec_q [6];
  logic signed [VecW-1:0]   vsel [3];
  logic                     vzero;

  logic [MagW-1:0] mag_q [3];
  logic [MagW-1:0] orm;
  logic            shr, shl;

  logic [SqW-1:0] n_q, res_q, bit_q;
  logic [SqW-1:0] sq_t, res_d;
  logic           sq_ge;
  logic [LenW-1:0] len_q;

  logic [RemW-1:0] rem_q, dsh_q;
  logic [QW-1:0]   q_q, qf;
  logic            div_ge;
  logic            div_last;
  logic [OutW-1:0] qs;
  logic [2:0]      ridx;
  logic [OutW-1:0] res_o_q [6];
  logic            out_free;

  assign cmd        = cmd_e'(s_axis_tuser);
  assign accept     = s_axis_tvalid && s_axis_tready;
  assign face_start = accept && (cmd == CMD_FACE);
  assign out_free   = !m_axis_tvalid || m_axis_tready;

  tgf_store #(.DEPTH(POSITION_DEPTH), .WIDTH(PosW)) u_pos_store (
    .clk_i   (clk_i),
    .we_i    (accept && (cmd == CMD_LOAD_POS)),
    .waddr_i (s_axis_tdata[IdxW-1:0]),
    .wdata_i (s_axis_tdata[IdxW+PosW-1:IdxW]),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  tgf_store #(.DEPTH(UV_DEPTH), .WIDTH(UvW)) u_uv_store (
    .clk_i   (clk_i),
    .we_i    (accept && (cmd == CMD_LOAD_UV)),
    .waddr_i (s_axis_tdata[IdxW-1:0]),
    .wdata_i (s_axis_tdata[IdxW+UvW-1:IdxW]),
    .raddr_i (uv_raddr),
    .rdata_o (uv_rdata)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pr[i]   = pos_rdata[CoordW*i +: CoordW];
      vsel[i] = vi_q ? vec_q[i+3] : vec_q[i];
    end
    for (int j = 0; j < 2; j++) begin
      ur[j] = uv_rdata[CoordW*j +: CoordW];
    end
  end

  assign vzero = (vsel[0] == '0) && (vsel[1] == '0) && (vsel[2] == '0);
  assign diff  = acc_q - VecW'(prod_q);
  assign orm   = mag_q[0] | mag_q[1] | mag_q[2];
  assign shr   = (orm[MagW-1:NormW] != '0);
  assign shl   = !orm[NormW-1];

  assign sq_t  = res_q + bit_q;
  assign sq_ge = (n_q >= sq_t);
  assign res_d = sq_ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);

  assign div_ge   = (rem_q >= dsh_q);
  assign qf       = {q_q[QW-2:0], div_ge};
  assign div_last = (cnt_q == 4'(QW - 1));
  assign qs       = vsel[k_q[1:0]][VecW-1] ? -OutW'({1'b0, qf}) : OutW'({1'b0, qf});
  assign ridx     = vi_q ? (3'(k_q[1:0]) + 3'd3) : 3'(k_q[1:0]);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == ST_SQ) begin
      mul_a = DeltaW'(mag_q[k_q[1:0]][NormW-1:0]);
      mul_b = DeltaW'(mag_q[k_q[1:0]][NormW-1:0]);
    end else begin
      case (k_q)
        4'd0:    begin mul_a = du1_q; mul_b = dv2_q;   end
        4'd1:    begin mul_a = du2_q; mul_b = dv1_q;   end
        4'd2:    begin mul_a = dv2_q; mul_b = e1_q[0]; end
        4'd3:    begin mul_a = dv1_q; mul_b = e2_q[0]; end
        4'd4:    begin mul_a = dv2_q; mul_b = e1_q[1]; end
        4'd5:    begin mul_a = dv1_q; mul_b = e2_q[1]; end
        4'd6:    begin mul_a = dv2_q; mul_b = e1_q[2]; end
        4'd7:    begin mul_a = dv1_q; mul_b = e2_q[2]; end
        4'd8:    begin mul_a = du1_q; mul_b = e2_q[0]; end
        4'd9:    begin mul_a = du2_q; mul_b = e1_q[0]; end
        4'd10:   begin mul_a = du1_q; mul_b = e2_q[1]; end
        4'd11:   begin mul_a = du2_q; mul_b = e1_q[1]; end
        4'd12:   begin mul_a = du1_q; mul_b = e2_q[2]; end
        4'd13:   begin mul_a = du2_q; mul_b = e1_q[2]; end
        default: begin mul_a = '0;    mul_b = '0;      end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (face_start) state_d = ST_RD_A;
      ST_RD_A:     state_d = ST_RD_B;
      ST_RD_B:     state_d = ST_RD_C;
      ST_RD_C:     state_d = ST_RD_END;
      ST_RD_END:   state_d = ST_MUL;
      ST_MUL: begin
        if (ph_q) begin
          if ((k_q == 4'd1) && (diff == '0)) begin
            state_d = ST_DONE;
          end else if (k_q == 4'd13) begin
            state_d = ST_ABS;
          end
        end
      end
      ST_ABS:      state_d = vzero ? ST_DONE : ST_SHIFT;
      ST_SHIFT:    if (!shr && !shl) state_d = ST_SQ;
      ST_SQ:       if (ph_q && (k_q == 4'd2)) state_d = ST_SQRT;
      ST_SQRT:     if (bit_q[0]) state_d = ST_DIV_INIT;
      ST_DIV_INIT: state_d = ST_DIV;
      ST_DIV: begin
        if (div_last) begin
          if (k_q != 4'd2) begin
            state_d = ST_DIV_INIT;
          end else begin
            state_d = vi_q ? ST_DONE : ST_ABS;
          end
        end
      end
      ST_DONE:     if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    case (state_q)
      ST_RD_B: begin
        pos_raddr = pidx_q[1];
        uv_raddr  = uidx_q[1];
      end
      ST_RD_C: begin
        pos_raddr = pidx_q[2];
        uv_raddr  = uidx_q[2];
      end
      default: begin
        pos_raddr = pidx_q[0];
        uv_raddr  = uidx_q[0];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      k_q           <= '0;
      ph_q          <= 1'b0;
      vi_q          <= 1'b0;
      cnt_q         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == ST_DONE) && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state_q)
        ST_RD_END: begin
          k_q  <= '0;
          ph_q <= 1'b0;
          vi_q <= 1'b0;
        end
        ST_MUL, ST_SQ: begin
          ph_q <= !ph_q;
          if (ph_q) k_q <= k_q + 4'd1;
        end
        ST_SHIFT: begin
          k_q  <= '0;
          ph_q <= 1'b0;
        end
        ST_SQRT: k_q <= '0;
        ST_DIV_INIT: cnt_q <= '0;
        ST_DIV: begin
          cnt_q <= cnt_q + 4'd1;
          if (div_last) begin
            if (k_q != 4'd2) begin
              k_q <= k_q + 4'd1;
            end else begin
              vi_q <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        degen_q <= 1'b0;
        if (face_start) begin
          for (int i = 0; i < 3; i++) begin
            pidx_q[i] <= s_axis_tdata[108 + IdxW*i +: IdxW];
            uidx_q[i] <= s_axis_tdata[144 + IdxW*i +: IdxW];
          end
        end
      end
      ST_RD_B: begin
        p0_q <= pr;
        t0_q <= ur;
      end
      ST_RD_C: begin
        for (int i = 0; i < 3; i++) e1_q[i] <= sat_delta(pr[i], p0_q[i]);
        du1_q <= sat_delta(ur[0], t0_q[0]);
        dv1_q <= sat_delta(ur[1], t0_q[1]);
      end
      ST_RD_END: begin
        for (int i = 0; i < 3; i++) e2_q[i] <= sat_delta(pr[i], p0_q[i]);
        du2_q <= sat_delta(ur[0], t0_q[0]);
        dv2_q <= sat_delta(ur[1], t0_q[1]);
      end
      ST_MUL: begin
        if (!ph_q) begin
          prod_q <= mul_a * mul_b;
        end else if (!k_q[0]) begin
          acc_q <= VecW'(prod_q);
        end else if (k_q == 4'd1) begin
          det_neg_q <= diff[VecW-1];
          if (diff == '0) degen_q <= 1'b1;
        end else begin
          vec_q[3'(k_q >> 1) - 3'd1] <= det_neg_q ? -diff : diff;
        end
      end
      ST_ABS: begin
        for (int i = 0; i < 3; i++) begin
          mag_q[i] <= vsel[i][VecW-1] ? MagW'(-vsel[i]) : MagW'(vsel[i]);
        end
        if (vzero) degen_q <= 1'b1;
      end
      ST_SHIFT: begin
        n_q <= '0;
        for (int i = 0; i < 3; i++) begin
          if (shr) begin
            mag_q[i] <= mag_q[i] >> 1;
          end else if (shl) begin
            mag_q[i] <= mag_q[i] << 1;
          end
        end
      end
      ST_SQ: begin
        if (!ph_q) begin
          prod_q <= mul_a * mul_b;
        end else begin
          n_q <= n_q + SqW'(prod_q);
        end
        res_q <= '0;
        bit_q <= SqrtTopBit;
      end
      ST_SQRT: begin
        if (sq_ge) n_q <= n_q - sq_t;
        res_q <= res_d;
        bit_q <= bit_q >> 2;
        len_q <= res_d[LenW-1:0];
      end
      ST_DIV_INIT: begin
        rem_q <= RemW'({mag_q[k_q[1:0]][NormW-1:0], {(QW-1){1'b0}}})
                 + RemW'(len_q >> 1);
        dsh_q <= {len_q, {(QW-1){1'b0}}};
        q_q   <= '0;
      end
      ST_DIV: begin
        if (div_ge) rem_q <= rem_q - dsh_q;
        dsh_q <= dsh_q >> 1;
        q_q   <= qf;
        if (div_last) res_o_q[ridx] <= qs;
      end
      ST_DONE: begin
        if (out_free) begin
          for (int i = 0; i < 6; i++) begin
            m_axis_tdata[OutW*i +: OutW] <= degen_q ? '0 : res_o_q[i];
          end
          m_axis_tuser <= degen_q;
        end
      end
      default: ;
    endcase
  end

endmodule

### design/tgf_store.sv
module tgf_store
  import tgf_pkg::*;
#(
  parameter int DEPTH = PositionDepthDef,
  parameter int WIDTH = PosW
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IdxW-1:0]  waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [IdxW-1:0]  raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;
  logic             rin_q;
  logic             win;
  logic             rin;

  assign win = (32'(waddr_i) < DEPTH);
  assign rin = (32'(raddr_i) < DEPTH);

  always_ff @(posedge clk_i) begin
    if (we_i && win) begin
      mem[AW'(waddr_i)] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[AW'(raddr_i)];
    rin_q   <= rin;
  end

  assign rdata_o = rin_q ? rdata_q : '0;

endmodule
